[hw/rtl/spc_pkg.sv]
// Shared constants, codes and types of the sponge permutation stream cipher unit.
package spc_pkg;

    localparam int PERM_SIZE    = 256;
    localparam int PERM_AW      = $clog2(PERM_SIZE);
    localparam int DATA_W       = 8;
    localparam int NIBBLE_SLOTS = 16;
    localparam int NIBBLE_BASE  = PERM_SIZE - NIBBLE_SLOTS;

    typedef enum logic [1:0] {
        FN_INIT    = 2'd0,
        FN_ABSORB  = 2'd1,
        FN_ENCRYPT = 2'd2,
        FN_SQUEEZE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPD0,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_UPD4,
        ST_NIB_CHK,
        ST_NIB_RD0,
        ST_NIB_RD1,
        ST_NIB_WR0,
        ST_NIB_WR1,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        func_t             func;
        logic [DATA_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } res_t;

endpackage

[hw/rtl/spc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/spc_core.sv]
// Sequencer that runs clearing, updates, shuffles and nibble absorption on the permutation memory.
module spc_core (
    input  logic          clk,
    input  logic          rst_n,
    input  spc_pkg::req_t req,
    output logic          req_ready,
    output spc_pkg::res_t res,
    input  logic          res_ready
);

    localparam logic [spc_pkg::PERM_AW-1:0] LAST_IDX =
        spc_pkg::PERM_AW'(spc_pkg::PERM_SIZE - 1);
    localparam logic [spc_pkg::PERM_AW-1:0] NIB_BASE_IDX =
        spc_pkg::PERM_AW'(spc_pkg::NIBBLE_BASE);
    localparam logic [7:0] NIB_LIMIT = 8'(spc_pkg::NIBBLE_BASE);

    spc_pkg::state_t state_reg, state_next;
    logic boot_reg, boot_next;
    logic shuf_reg, shuf_next;
    logic nib_sel_reg, nib_sel_next;
    logic [spc_pkg::PERM_AW-1:0] cnt_reg, cnt_next;
    logic [spc_pkg::PERM_AW-1:0] i_reg, i_next;
    logic [spc_pkg::PERM_AW-1:0] j_reg, j_next;
    logic [7:0] w_reg, w_next;
    logic [7:0] nib_reg, nib_next;
    spc_pkg::func_t func_reg, func_next;
    logic [spc_pkg::DATA_W-1:0] byte_reg, byte_next;
    logic [spc_pkg::DATA_W-1:0] a_reg, a_next;
    logic [spc_pkg::DATA_W-1:0] res_reg, res_next;

    logic                        wr_en;
    logic [spc_pkg::PERM_AW-1:0] wr_addr;
    logic [spc_pkg::DATA_W-1:0]  wr_data;
    logic                        rd_en;
    logic [spc_pkg::PERM_AW-1:0] rd_addr;
    logic [spc_pkg::DATA_W-1:0]  rd_data;

    logic [3:0]                  nib_x;
    logic [spc_pkg::PERM_AW-1:0] nib_q;
    logic [spc_pkg::PERM_AW-1:0] ni;

    spc_ram #(
        .WIDTH(spc_pkg::DATA_W),
        .DEPTH(spc_pkg::PERM_SIZE)
    ) u_perm_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign nib_x = nib_sel_reg ? byte_reg[7:4] : byte_reg[3:0];
    assign nib_q = NIB_BASE_IDX + spc_pkg::PERM_AW'(nib_x);
    assign ni    = i_reg + w_reg[spc_pkg::PERM_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= spc_pkg::ST_CLEAR;
            boot_reg    <= 1'b1;
            shuf_reg    <= 1'b0;
            nib_sel_reg <= 1'b0;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            w_reg       <= 8'd1;
            nib_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            boot_reg    <= boot_next;
            shuf_reg    <= shuf_next;
            nib_sel_reg <= nib_sel_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            w_reg       <= w_next;
            nib_reg     <= nib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        byte_reg <= byte_next;
        a_reg    <= a_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        boot_next    = boot_reg;
        shuf_next    = shuf_reg;
        nib_sel_next = nib_sel_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        w_next       = w_reg;
        nib_next     = nib_reg;
        func_next    = func_reg;
        byte_next    = byte_reg;
        a_next       = a_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        req_ready    = 1'b0;
        res.valid    = 1'b0;
        res.data     = res_reg;

        case (state_reg)
            spc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    func_next = req.func;
                    byte_next = req.data;
                    res_next  = '0;
                    case (req.func)
                        spc_pkg::FN_INIT:
                        begin
                            cnt_next   = '0;
                            i_next     = '0;
                            j_next     = '0;
                            w_next     = 8'd1;
                            nib_next   = '0;
                            state_next = spc_pkg::ST_CLEAR;
                        end
                        spc_pkg::FN_ABSORB:
                        begin
                            nib_sel_next = 1'b0;
                            state_next   = spc_pkg::ST_NIB_CHK;
                        end
                        spc_pkg::FN_ENCRYPT:
                        begin
                            shuf_next  = 1'b0;
                            state_next = spc_pkg::ST_UPD0;
                        end
                        default:
                        begin
                            shuf_next  = (nib_reg != 8'd0);
                            cnt_next   = '0;
                            state_next = spc_pkg::ST_UPD0;
                        end
                    endcase
                end
            end
            spc_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = spc_pkg::DATA_W'(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    boot_next  = 1'b0;
                    state_next = boot_reg ? spc_pkg::ST_IDLE : spc_pkg::ST_DONE;
                end
            end
            spc_pkg::ST_UPD0:
            begin
                rd_en      = 1'b1;
                rd_addr    = ni;
                i_next     = ni;
                state_next = spc_pkg::ST_UPD1;
            end
            spc_pkg::ST_UPD1:
            begin
                a_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = j_reg + rd_data[spc_pkg::PERM_AW-1:0];
                state_next = spc_pkg::ST_UPD2;
            end
            spc_pkg::ST_UPD2:
            begin
                j_next     = rd_data[spc_pkg::PERM_AW-1:0];
                rd_en      = 1'b1;
                rd_addr    = rd_data[spc_pkg::PERM_AW-1:0];
                state_next = spc_pkg::ST_UPD3;
            end
            spc_pkg::ST_UPD3:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_data;
                state_next = spc_pkg::ST_UPD4;
            end
            spc_pkg::ST_UPD4:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = a_reg;
                if (shuf_reg)
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        shuf_next = 1'b0;
                        cnt_next  = '0;
                        w_next    = w_reg + 8'd2;
                        nib_next  = '0;
                        if (func_reg == spc_pkg::FN_SQUEEZE)
                        begin
                            state_next = spc_pkg::ST_UPD0;
                        end
                        else
                        begin
                            state_next = spc_pkg::ST_NIB_RD0;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = spc_pkg::ST_UPD0;
                    end
                end
                else if (func_reg == spc_pkg::FN_ENCRYPT)
                begin
                    // After the swap the entry at j holds the value read at i.
                    res_next     = byte_reg ^ a_reg;
                    byte_next    = byte_reg ^ a_reg;
                    nib_sel_next = 1'b0;
                    state_next   = spc_pkg::ST_NIB_CHK;
                end
                else
                begin
                    res_next   = a_reg;
                    state_next = spc_pkg::ST_DONE;
                end
            end
            spc_pkg::ST_NIB_CHK:
            begin
                if (nib_reg >= NIB_LIMIT)
                begin
                    shuf_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = spc_pkg::ST_UPD0;
                end
                else
                begin
                    state_next = spc_pkg::ST_NIB_RD0;
                end
            end
            spc_pkg::ST_NIB_RD0:
            begin
                rd_en      = 1'b1;
                rd_addr    = nib_reg[spc_pkg::PERM_AW-1:0];
                state_next = spc_pkg::ST_NIB_RD1;
            end
            spc_pkg::ST_NIB_RD1:
            begin
                a_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = nib_q;
                state_next = spc_pkg::ST_NIB_WR0;
            end
            spc_pkg::ST_NIB_WR0:
            begin
                wr_en      = 1'b1;
                wr_addr    = nib_reg[spc_pkg::PERM_AW-1:0];
                wr_data    = rd_data;
                state_next = spc_pkg::ST_NIB_WR1;
            end
            spc_pkg::ST_NIB_WR1:
            begin
                wr_en    = 1'b1;
                wr_addr  = nib_q;
                wr_data  = a_reg;
                nib_next = nib_reg + 8'd1;
                if (nib_sel_reg)
                begin
                    state_next = spc_pkg::ST_DONE;
                end
                else
                begin
                    nib_sel_next = 1'b1;
                    state_next   = spc_pkg::ST_NIB_CHK;
                end
            end
            spc_pkg::ST_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = spc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spc_pkg::ST_IDLE;
            end
        endcase
    end

    // The sequence never reads and writes the memory in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("Permutation memory read and write in the same cycle.");

    a_nib_limit: assert property (@(posedge clk) disable iff (!rst_n)
        nib_reg <= NIB_LIMIT)
        else $error("Nibble counter passed the shuffle threshold.");

    a_nib_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spc_pkg::ST_NIB_WR0) |-> (wr_addr < NIB_BASE_IDX))
        else $error("Nibble swap hit the nibble slot region.");

    a_step_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spc_pkg::ST_UPD4 && shuf_reg && cnt_reg == LAST_IDX)
        |=> (w_reg == $past(w_reg) + 8'd2 && nib_reg == 8'd0))
        else $error("Shuffle ended without advancing the step.");

endmodule

[hw/rtl/sponge_permutation_stream_cipher_unit.sv]
// Top level of the sponge permutation stream cipher unit with stream ports and output register.
//
// Each request on the slave stream carries a function code in tuser and a byte in tdata and
// produces exactly one byte on the master stream. The permutation sits in one memory with one
// write and one registered read port, and every update consists there of three dependent
// reads (i, j plus that entry, the new j) and two writes for the swap. Absorbing a nibble
// reads two entries and writes them back swapped; whenever a shuffle is due it adds 256
// updates. Init rewrites the identity one entry a cycle. After reset the same clearing pass
// runs before the first request is taken. A finished byte waits in an output register, so the
// next request is accepted while the downstream side stalls.
module sponge_permutation_stream_cipher_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_in
    input  logic [1:0] s_axis_tuser,  // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [7:0] data_out
);

    spc_pkg::req_t req;
    spc_pkg::res_t res;
    logic          res_ready;

    logic                       out_valid_reg, out_valid_next;
    logic [spc_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    assign req.valid = s_axis_tvalid;
    assign req.func  = spc_pkg::func_t'(s_axis_tuser);
    assign req.data  = s_axis_tdata;

    assign res_ready = !out_valid_reg || m_axis_tready;

    spc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .req_ready(s_axis_tready),
        .res      (res),
        .res_ready(res_ready)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
